// File: sv/iopr_pkg.sv
// Shared types and constants for the in-order page release block.
// No dependencies.
`default_nettype none

package iopr_pkg;

  localparam int unsigned MaxPages = 64;
  localparam int unsigned IdxW     = 6;
  localparam int unsigned CntW     = 7;
  localparam int unsigned HandleW  = 32;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 56;

  localparam logic [CntW-1:0] MaxPagesCnt = CntW'(MaxPages);

  localparam logic ReqSubmit = 1'b0;
  localparam logic ReqFail   = 1'b1;

  typedef enum logic [1:0] {
    StIdle,
    StLook,
    StEmit
  } iopr_state_e;

  typedef struct packed {
    logic take;
    logic load;
    logic advance;
  } iopr_cmd_t;

  typedef struct packed {
    logic out_free;
    logic cur_ready;
    logic next_ready;
  } iopr_sts_t;

endpackage

`default_nettype wire

// File: sv/iopr_ctrl.sv
// Controller state machine: request intake and release sequencing.
// Depends on iopr_pkg.
`default_nettype none

module iopr_ctrl
  import iopr_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire iopr_sts_t sts_i,
  output iopr_cmd_t      cmd_o
);

  iopr_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = StLook;
        end
      end
      StLook: begin
        state_d = StEmit;
      end
      StEmit: begin
        if (sts_i.out_free && (!sts_i.cur_ready || !sts_i.next_ready)) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        cmd_o.take = in_valid_i;
      end
      StLook: begin
      end
      StEmit: begin
        cmd_o.load    = sts_i.out_free;
        cmd_o.advance = sts_i.out_free && sts_i.cur_ready;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// File: sv/iopr_datapath.sv
// Datapath: slot flags, handle memory, release pointer, totals, output register.
// Depends on iopr_pkg; driven by iopr_ctrl commands.
`default_nettype none

module iopr_datapath
  import iopr_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CntW-1:0]     cfg_wdata_i,
  input  wire logic                in_type_i,
  input  wire logic [IdxW-1:0]     in_index_i,
  input  wire logic [HandleW-1:0]  in_handle_i,
  input  wire iopr_cmd_t           cmd_i,
  output iopr_sts_t                sts_o,
  input  wire logic                out_ready_i,
  output logic                     out_valid_o,
  output logic [OutDataW-1:0]      out_data_o,
  output logic                     out_last_o
);

  logic [CntW-1:0]     page_count_q;
  logic [CntW-1:0]     eff_cnt;
  logic [MaxPages-1:0] filled_q;
  logic [MaxPages-1:0] failed_q;
  logic [HandleW-1:0]  mem_q [MaxPages];
  logic [HandleW-1:0]  rd_q;
  logic [CntW-1:0]     nr_q, nr_d, nr_next;
  logic [CntW-1:0]     written_q, failed_tot_q;
  logic                acc_q;
  logic                hit;
  logic                cur_fail;
  logic                rel_write, rel_skip;
  logic [CntW-1:0]     written_out, failed_out, nr_after;
  logic                out_valid_q;
  logic [OutDataW-1:0] out_data_q;
  logic                out_last_q;

  assign eff_cnt = (page_count_q > MaxPagesCnt) ? MaxPagesCnt : page_count_q;
  assign hit     = ({1'b0, in_index_i} < eff_cnt) && !filled_q[in_index_i];

  assign nr_next  = nr_q + CntW'(1);
  assign nr_d     = cmd_i.advance ? nr_next : nr_q;
  assign cur_fail = failed_q[nr_q[IdxW-1:0]];

  assign sts_o.cur_ready  = (nr_q < eff_cnt) && filled_q[nr_q[IdxW-1:0]];
  assign sts_o.next_ready = (nr_next < eff_cnt) && filled_q[nr_next[IdxW-1:0]];
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign rel_write   = sts_o.cur_ready && !cur_fail;
  assign rel_skip    = sts_o.cur_ready && cur_fail;
  assign written_out = written_q + CntW'(rel_write);
  assign failed_out  = failed_tot_q + CntW'(rel_skip);
  assign nr_after    = nr_q + CntW'(sts_o.cur_ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_count_q <= MaxPagesCnt;
    end else if (cfg_we_i) begin
      page_count_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filled_q <= '0;
      failed_q <= '0;
      acc_q    <= 1'b0;
    end else if (cmd_i.take) begin
      acc_q <= hit;
      if (hit) begin
        filled_q[in_index_i] <= 1'b1;
        failed_q[in_index_i] <= (in_type_i == ReqFail);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take && hit && (in_type_i == ReqSubmit)) begin
      mem_q[in_index_i] <= in_handle_i;
    end
    rd_q <= mem_q[nr_d[IdxW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nr_q         <= '0;
      written_q    <= '0;
      failed_tot_q <= '0;
    end else if (cmd_i.advance) begin
      nr_q         <= nr_next;
      written_q    <= written_out;
      failed_tot_q <= failed_out;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_data_q <= {nr_after >= eff_cnt,
                     failed_out,
                     written_out,
                     rel_skip,
                     rel_write ? rd_q : HandleW'(0),
                     sts_o.cur_ready ? nr_q[IdxW-1:0] : IdxW'(0),
                     sts_o.cur_ready,
                     acc_q};
      out_last_q <= !sts_o.cur_ready || !sts_o.next_ready;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;

  a_adv_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.advance |-> sts_o.cur_ready)
    else $error("release pointer advanced over a slot that is not ready");

  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nr_q <= MaxPagesCnt)
    else $error("release pointer beyond slot range");

  a_totals: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (written_q + failed_tot_q) == nr_q)
    else $error("written and failed totals disagree with release pointer");

  a_released_filled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.advance |=> filled_q[$past(nr_q[IdxW-1:0])])
    else $error("released slot not marked filled");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !cmd_i.load)
    else $error("output register overwritten while stalled");

endmodule

`default_nettype wire

// File: sv/in_order_page_release_top.sv
// In-order page release: a reorder buffer for completed pages.
// Depends on iopr_pkg, iopr_ctrl and iopr_datapath.
//
// Input stream: one transaction is a request. tuser is the request type
// (submit a page handle or mark a page failed); tdata carries the slot index
// and the handle. Output stream: each request yields one or more
// transactions, the final one flagged by tlast. A request that releases
// nothing yields a single transaction with release_valid low.
// Configuration: cfg_we_i writes page_count; write it only while idle.
// Timing: a request is taken in the idle state, the handle memory is read
// in the look state, then one result per cycle is loaded into the output
// register in the emit state while the receiver does not stall. A request
// holds the block from intake until its last result is loaded, paced by the
// single read port of the handle memory and the one-slot-per-cycle drain.
// tready stays high when idle, also while a result waits in the output
// register. A stalled receiver holds the output register and the drain.
// Reset clears all slot flags, the release pointer, totals and sets
// page_count to 64; the handle memory is not cleared and needs no sweep.
`default_nettype none

module in_order_page_release_top
  import iopr_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CntW-1:0]     cfg_wdata_i,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // [5:0] slot index, [37:6] page handle, [39:38] zero
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  // [0] req_type
  input  wire logic                s_axis_tuser,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // [0] accepted, [1] release_valid, [7:2] released_index,
  // [39:8] released_handle, [40] skipped, [47:41] written_count,
  // [54:48] failed_count, [55] all_done
  output logic [OutDataW-1:0]      m_axis_tdata,
  output logic                     m_axis_tlast
);

  iopr_cmd_t cmd;
  iopr_sts_t sts;

  iopr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  iopr_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_type_i   (s_axis_tuser),
    .in_index_i  (s_axis_tdata[IdxW-1:0]),
    .in_handle_i (s_axis_tdata[IdxW+HandleW-1:IdxW]),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

`default_nettype wire

// File: tb/tb_in_order_page_release_top.sv
// Self-checking testbench for in_order_page_release_top: out-of-order page
// requests in, in-order release transactions out, checked against a predictor.
// Depends on iopr_pkg and the in_order_page_release_top RTL.
module tb_in_order_page_release_top;
  import iopr_pkg::*;

  localparam int unsigned StallLimit = 1000;
  localparam int unsigned ItemTarget = 280;

  typedef enum logic [1:0] {
    SlotEmpty,
    SlotPending,
    SlotReleased,
    SlotFailed
  } slot_state_e;

  typedef struct packed {
    logic               kind;
    logic [IdxW-1:0]    index;
    logic [HandleW-1:0] handle;
  } page_req_t;

  typedef struct packed {
    logic               accepted;
    logic               release_valid;
    logic [IdxW-1:0]    index;
    logic [HandleW-1:0] handle;
    logic               skipped;
    logic [CntW-1:0]    written;
    logic [CntW-1:0]    failed;
    logic               all_done;
    logic               last;
  } release_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CntW-1:0]     cfg_wdata_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                s_axis_tuser = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;

  slot_state_e        slot_state [MaxPages] = '{default: SlotEmpty};
  logic [HandleW-1:0] slot_handle [MaxPages];
  logic [CntW-1:0]    next_page = '0;
  logic [CntW-1:0]    written_total = '0;
  logic [CntW-1:0]    failed_total = '0;
  logic [CntW-1:0]    page_limit = MaxPagesCnt;

  page_req_t   pending_requests[$];
  release_t    expected_releases[$];
  page_req_t   cur_req;
  release_t    want_rel;
  logic        idle_on = 1'b1;
  int unsigned src_gap = 0;
  int unsigned sink_gap = 0;
  int unsigned quiet_cycles = 0;
  int unsigned n_queued = 0;
  int unsigned n_requests = 0;
  int unsigned n_results = 0;
  int unsigned n_errors = 0;

  in_order_page_release_top u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic slot_ready(logic [CntW-1:0] slot, logic [CntW-1:0] lim);
    if (slot >= lim) return 1'b0;
    return slot_state[slot[IdxW-1:0]] == SlotPending ||
           slot_state[slot[IdxW-1:0]] == SlotFailed;
  endfunction

  // Apply one request to the slot table and queue the releases it drains.
  function automatic void release_pages(page_req_t r);
    logic [CntW-1:0] lim;
    logic            acc;
    int unsigned     n;
    release_t        e;
    lim = (page_limit > MaxPagesCnt) ? MaxPagesCnt : page_limit;
    acc = 1'b0;
    n = 0;
    if (CntW'(r.index) < lim && slot_state[r.index] == SlotEmpty) begin
      if (r.kind == ReqSubmit) begin
        slot_state[r.index] = SlotPending;
        slot_handle[r.index] = r.handle;
      end else begin
        slot_state[r.index] = SlotFailed;
      end
      acc = 1'b1;
    end
    while (n < MaxPages && slot_ready(next_page, lim)) begin
      e = '0;
      e.accepted = acc;
      e.release_valid = 1'b1;
      e.index = next_page[IdxW-1:0];
      if (slot_state[e.index] == SlotFailed) begin
        e.skipped = 1'b1;
        failed_total++;
      end else begin
        e.handle = slot_handle[e.index];
        slot_state[e.index] = SlotReleased;
        written_total++;
      end
      next_page++;
      n++;
      e.written = written_total;
      e.failed = failed_total;
      e.all_done = next_page >= lim;
      e.last = !(n < MaxPages && slot_ready(next_page, lim));
      expected_releases.push_back(e);
    end
    if (n == 0) begin
      e = '0;
      e.accepted = acc;
      e.written = written_total;
      e.failed = failed_total;
      e.all_done = next_page >= lim;
      e.last = 1'b1;
      expected_releases.push_back(e);
    end
  endfunction

  function automatic void check_field(string name, longint unsigned want,
                                      longint unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      n_errors++;
    end
  endfunction

  // Driver: offer queued requests, predict each accepted transaction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        release_pages(cur_req);
        n_requests++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (idle_on && src_gap > 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_requests.size() != 0) begin
          cur_req = pending_requests.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= cur_req.kind;
          s_axis_tdata <= InDataW'({cur_req.handle, cur_req.index});
          if (idle_on && $urandom_range(0, 99) < 12) src_gap = $urandom_range(1, 19);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each output transaction with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_results++;
        if (expected_releases.size() == 0) begin
          $error("unexpected result: tdata %0h tlast %0b", m_axis_tdata, m_axis_tlast);
          n_errors++;
          $display("Verification failed");
          $finish;
        end else begin
          want_rel = expected_releases.pop_front();
          check_field("accepted", want_rel.accepted, m_axis_tdata[0]);
          check_field("release_valid", want_rel.release_valid, m_axis_tdata[1]);
          check_field("released_index", want_rel.index, m_axis_tdata[7:2]);
          check_field("released_handle", want_rel.handle, m_axis_tdata[39:8]);
          check_field("skipped", want_rel.skipped, m_axis_tdata[40]);
          check_field("written_count", want_rel.written, m_axis_tdata[47:41]);
          check_field("failed_count", want_rel.failed, m_axis_tdata[54:48]);
          check_field("all_done", want_rel.all_done, m_axis_tdata[55]);
          check_field("last", want_rel.last, m_axis_tlast);
        end
      end
      if (idle_on && sink_gap > 0) begin
        sink_gap--;
        m_axis_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 99) < 10) begin
        sink_gap = $urandom_range(0, 18);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("timeout: %0d cycles without a transaction", quiet_cycles);
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic queue_request(logic kind, int unsigned idx, logic [HandleW-1:0] h);
    page_req_t r;
    r.kind = kind;
    r.index = IdxW'(idx);
    r.handle = h;
    pending_requests.push_back(r);
    n_queued++;
  endtask

  task automatic queue_noise(int unsigned hi);
    int unsigned idx;
    idx = $urandom_range(0, 1) ? $urandom_range(0, MaxPages - 1) : $urandom_range(0, hi - 1);
    queue_request(logic'($urandom_range(0, 1)), idx, $urandom());
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    while (pending_requests.size() != 0 || s_axis_tvalid || expected_releases.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_page_limit(logic [CntW-1:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    page_limit = value;
    @(negedge clk_i);
  endtask

  // Open a window of slots past the release point and fill it in some order.
  task automatic fill_window();
    int unsigned lo, hi, span, pick, s, j, tmp;
    int unsigned order_q[$];
    lo = next_page;
    span = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 12);
    hi = (lo + span > MaxPages) ? MaxPages : lo + span;
    if (hi == MaxPages && $urandom_range(0, 1)) begin
      set_page_limit(CntW'(MaxPages + $urandom_range(0, 63)));
    end else begin
      set_page_limit(CntW'(hi));
    end
    pick = $urandom_range(0, 2);
    for (s = lo; s < hi; s++) begin
      if (pick == 1) order_q.push_front(s);
      else order_q.push_back(s);
    end
    if (pick == 2) begin
      for (s = order_q.size(); s > 1; s--) begin
        j = $urandom_range(0, s - 1);
        tmp = order_q[s-1];
        order_q[s-1] = order_q[j];
        order_q[j] = tmp;
      end
    end
    foreach (order_q[k]) begin
      if ($urandom_range(0, 1)) queue_noise(hi);
      queue_request(($urandom_range(0, 99) < 20) ? ReqFail : ReqSubmit, order_q[k], $urandom());
    end
    wait_drained();
  endtask

  initial begin
    int unsigned remaining;
    logic [CntW-1:0] tail_limits [4];
    tail_limits = '{CntW'(0), CntW'(1), CntW'(64), CntW'(100)};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    set_page_limit(CntW'(0));
    queue_request(ReqSubmit, 0, 32'hFFFF_FFFF);
    queue_request(ReqFail, 63, 32'h0000_0000);
    wait_drained();

    set_page_limit(CntW'(4));
    queue_request(ReqSubmit, 3, 32'hFFFF_FFFF);
    queue_request(ReqFail, 1, 32'h0000_0000);
    queue_request(ReqSubmit, 4, 32'h1234_5678);
    queue_request(ReqSubmit, 63, 32'h0000_0000);
    queue_request(ReqSubmit, 0, 32'h0000_0000);
    queue_request(ReqSubmit, 0, 32'hDEAD_BEEF);
    queue_request(ReqFail, 3, 32'h0000_0000);
    queue_request(ReqFail, 1, 32'h0000_0000);
    queue_request(ReqSubmit, 2, 32'hA5A5_A5A5);
    queue_request(ReqSubmit, 1, 32'h8000_0001);
    wait_drained();

    set_page_limit(CntW'(127));
    queue_request(ReqFail, 5, 32'h0000_0000);
    queue_request(ReqSubmit, 5, 32'h0F0F_0F0F);
    queue_request(ReqFail, 4, 32'h0000_0000);
    queue_request(ReqSubmit, 7, 32'h5A5A_5A5A);
    wait_drained();

    set_page_limit(CntW'(2));
    queue_request(ReqSubmit, 6, 32'h7FFF_FFFE);
    queue_request(ReqFail, 0, 32'h0000_0000);
    wait_drained();

    while (next_page < MaxPagesCnt) fill_window();

    idle_on = 1'b0;
    remaining = (n_queued < ItemTarget) ? ItemTarget - n_queued : 8;
    foreach (tail_limits[t]) begin
      set_page_limit(tail_limits[t]);
      repeat (remaining / 4 + 1) queue_noise(MaxPages);
      wait_drained();
    end

    repeat (10) @(posedge clk_i);
    $display("Covered %0d requests and %0d result transactions: %0d pages written, %0d skipped.",
             n_requests, n_results, written_total, failed_total);
    $display("Page counts from 0 to 127, rejections and drains up to the full buffer; %0d errors.",
             n_errors);
    if (n_errors == 0 && expected_releases.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
sv/iopr_pkg.sv
sv/iopr_ctrl.sv
sv/iopr_datapath.sv
sv/in_order_page_release_top.sv
tb/tb_in_order_page_release_top.sv
